// ===== hw/rtl/pwp_pkg.sv =====
// Shared types and codes for the protobuf wire format parser.
package pwp_pkg;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_FIX32   = 3'd5;
    localparam logic [2:0] PH_DRAIN   = 3'd6;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_LONG  = 2'd1;
    localparam logic [1:0] CAUSE_WIRE  = 2'd2;
    localparam logic [1:0] CAUSE_TRUNC = 2'd3;

    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [2:0] FIX32_LAST_IDX  = 3'd3;
    localparam logic [2:0] FIX64_LAST_IDX  = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] field;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic [7:0]  pbyte;
        logic        last;
        logic [1:0]  cause;
    } result_t;

endpackage

// ===== hw/rtl/pwp_in_stage.sv =====
// Input register for incoming message bytes.
module pwp_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  pwp_pkg::beat_t beat_in,
    input  logic           advance,
    output logic           held_valid,
    output pwp_pkg::beat_t held_beat
);

    logic           valid_reg;
    pwp_pkg::beat_t beat_reg;

    assign byte_stall = valid_reg && !advance;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            beat_reg <= beat_in;
        end
    end

endmodule

// ===== hw/rtl/pwp_decoder.sv =====
// Wire format state and per-byte decode logic.
module pwp_decoder
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  pwp_pkg::beat_t   beat,
    output logic             res_valid,
    output pwp_pkg::result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wire_reg, wire_next;

    logic [3:0]  idx_v;
    logic [2:0]  idx_f;
    logic [2:0]  top_f;
    logic [5:0]  sh_v;
    logic [63:0] acc_v;
    logic [63:0] acc_f;
    logic        pay_last;
    logic        bad_wire;
    logic        err;
    logic [1:0]  err_cause;
    logic [31:0] err_field;
    logic [2:0]  err_wire;
    logic [31:0] ef;
    logic [2:0]  ew;

    always_comb
    begin
        idx_v    = (idx_reg > pwp_pkg::VARINT_LAST_IDX) ? pwp_pkg::VARINT_LAST_IDX
                                                        : idx_reg;
        idx_f    = (idx_reg > 4'd7) ? 3'd7 : idx_reg[2:0];
        top_f    = (phase_reg == pwp_pkg::PH_FIX32) ? pwp_pkg::FIX32_LAST_IDX
                                                    : pwp_pkg::FIX64_LAST_IDX;
        sh_v     = 6'(idx_v) * 6'd7;
        acc_v    = acc_reg | (64'(beat.data[6:0]) << sh_v);
        acc_f    = acc_reg | (64'(beat.data) << {idx_f, 3'b000});
        pay_last = (rem_reg <= 64'd1);
        ef       = (phase_reg == pwp_pkg::PH_TAG) ? 32'd0 : field_reg;
        ew       = (phase_reg == pwp_pkg::PH_TAG) ? 3'd0 : wire_reg;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        bad_wire   = 1'b0;
        err        = 1'b0;
        err_cause  = pwp_pkg::CAUSE_NONE;
        err_field  = 32'd0;
        err_wire   = 3'd0;
        res_valid  = 1'b0;
        res        = '0;

        if (fire)
        begin
            unique case (phase_reg)
                pwp_pkg::PH_TAG, pwp_pkg::PH_VARINT, pwp_pkg::PH_LENGTH:
                begin
                    acc_next = acc_v;
                    if (beat.data[7])
                    begin
                        if (idx_v >= pwp_pkg::VARINT_LAST_IDX)
                        begin
                            err       = 1'b1;
                            err_cause = pwp_pkg::CAUSE_LONG;
                            err_field = ef;
                            err_wire  = ew;
                        end
                        else if (beat.eom)
                        begin
                            err       = 1'b1;
                            err_cause = pwp_pkg::CAUSE_TRUNC;
                            err_field = ef;
                            err_wire  = ew;
                        end
                        else
                        begin
                            idx_next = idx_v + 4'd1;
                        end
                    end
                    else
                    begin
                        acc_next = 64'd0;
                        idx_next = 4'd0;
                        if (phase_reg == pwp_pkg::PH_TAG)
                        begin
                            field_next = acc_v[34:3];
                            wire_next  = acc_v[2:0];
                            unique case (acc_v[2:0])
                                pwp_pkg::WT_VARINT: phase_next = pwp_pkg::PH_VARINT;
                                pwp_pkg::WT_FIX64:  phase_next = pwp_pkg::PH_FIX64;
                                pwp_pkg::WT_LEN:    phase_next = pwp_pkg::PH_LENGTH;
                                pwp_pkg::WT_FIX32:  phase_next = pwp_pkg::PH_FIX32;
                                default:            bad_wire   = 1'b1;
                            endcase
                            if (bad_wire || beat.eom)
                            begin
                                err       = 1'b1;
                                err_cause = bad_wire ? pwp_pkg::CAUSE_WIRE
                                                     : pwp_pkg::CAUSE_TRUNC;
                                err_field = acc_v[34:3];
                                err_wire  = acc_v[2:0];
                            end
                        end
                        else if (phase_reg == pwp_pkg::PH_VARINT)
                        begin
                            phase_next = pwp_pkg::PH_TAG;
                            res_valid  = 1'b1;
                            res.kind   = pwp_pkg::KIND_SCALAR;
                            res.field  = field_reg;
                            res.wtype  = wire_reg;
                            res.value  = acc_v;
                        end
                        else if ((acc_v != 64'd0) && beat.eom)
                        begin
                            err       = 1'b1;
                            err_cause = pwp_pkg::CAUSE_TRUNC;
                            err_field = field_reg;
                            err_wire  = wire_reg;
                        end
                        else
                        begin
                            rem_next   = acc_v;
                            phase_next = (acc_v == 64'd0) ? pwp_pkg::PH_TAG
                                                          : pwp_pkg::PH_PAYLOAD;
                            res_valid  = 1'b1;
                            res.kind   = pwp_pkg::KIND_HEADER;
                            res.field  = field_reg;
                            res.wtype  = wire_reg;
                            res.value  = acc_v;
                            res.last   = (acc_v == 64'd0);
                        end
                    end
                end
                pwp_pkg::PH_FIX32, pwp_pkg::PH_FIX64:
                begin
                    if (idx_f < top_f)
                    begin
                        acc_next = acc_f;
                        if (beat.eom)
                        begin
                            err       = 1'b1;
                            err_cause = pwp_pkg::CAUSE_TRUNC;
                            err_field = field_reg;
                            err_wire  = wire_reg;
                        end
                        else
                        begin
                            idx_next = 4'(idx_f) + 4'd1;
                        end
                    end
                    else
                    begin
                        acc_next   = 64'd0;
                        idx_next   = 4'd0;
                        phase_next = pwp_pkg::PH_TAG;
                        res_valid  = 1'b1;
                        res.kind   = pwp_pkg::KIND_SCALAR;
                        res.field  = field_reg;
                        res.wtype  = wire_reg;
                        res.value  = acc_f;
                    end
                end
                pwp_pkg::PH_PAYLOAD:
                begin
                    if (!pay_last && beat.eom)
                    begin
                        err       = 1'b1;
                        err_cause = pwp_pkg::CAUSE_TRUNC;
                        err_field = field_reg;
                        err_wire  = wire_reg;
                    end
                    else
                    begin
                        rem_next  = pay_last ? 64'd0 : rem_reg - 64'd1;
                        if (pay_last)
                        begin
                            phase_next = pwp_pkg::PH_TAG;
                        end
                        res_valid = 1'b1;
                        res.kind  = pwp_pkg::KIND_PAYLOAD;
                        res.field = field_reg;
                        res.wtype = wire_reg;
                        res.pbyte = beat.data;
                        res.last  = pay_last;
                    end
                end
                default:
                begin
                    if (beat.eom)
                    begin
                        phase_next = pwp_pkg::PH_TAG;
                        acc_next   = 64'd0;
                        idx_next   = 4'd0;
                    end
                end
            endcase

            if (err)
            begin
                phase_next = beat.eom ? pwp_pkg::PH_TAG : pwp_pkg::PH_DRAIN;
                acc_next   = 64'd0;
                idx_next   = 4'd0;
                res_valid  = 1'b1;
                res        = '0;
                res.kind   = pwp_pkg::KIND_ERROR;
                res.field  = err_field;
                res.wtype  = err_wire;
                res.cause  = err_cause;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pwp_pkg::PH_TAG;
            acc_reg   <= 64'd0;
            idx_reg   <= 4'd0;
            rem_reg   <= 64'd0;
            field_reg <= 32'd0;
            wire_reg  <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
        end
    end

endmodule

// ===== hw/rtl/pwp_out_stage.sv =====
// Result register holding one decoded item for the receiver.
module pwp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pwp_pkg::result_t res,
    output logic             ready,
    output logic             item_valid,
    input  logic             item_stall,
    output pwp_pkg::result_t item
);

    logic             valid_reg;
    pwp_pkg::result_t item_reg;

    assign ready      = !valid_reg || !item_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            item_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/protobuf_wire_parser_core.sv =====
// Top level of the protobuf wire format parser.
// Usage:
//   Byte channel: data_byte and end_of_message move on byte_valid when
//   byte_stall is low; end_of_message marks the last byte of a message.
//   Item channel: one decoded item (scalar field, bytes header, payload
//   byte or error) moves on item_valid when item_stall is low. A byte
//   gives zero or one item.
//   Path: a taken byte is held in the input register, then decoded into
//   the result register, where its item is presented on item_valid.
//   Throughput: one byte per cycle while item_stall is low; each byte needs
//   one shift-or of the 64-bit accumulator and a 64-bit length compare/decrement.
//   Stall: while item_stall holds a waiting item, the decoder stops and
//   byte_stall rises once the input register is occupied.
//   Reset: rst_n clears both registers' valid flags and returns the
//   decoder to expecting a tag with all counters zero.
//   After an error, bytes are dropped until end_of_message.
module protobuf_wire_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        item_valid,
    input  logic        item_stall,
    output logic [1:0]  item_kind,
    output logic [31:0] field_number,
    output logic [2:0]  wire_type,
    output logic [63:0] value,
    output logic [7:0]  payload_byte,
    output logic        last_of_field,
    output logic [1:0]  error_cause
);

    pwp_pkg::beat_t   beat_in;
    pwp_pkg::beat_t   held_beat;
    pwp_pkg::result_t res;
    pwp_pkg::result_t item;
    logic             held_valid;
    logic             out_ready;
    logic             advance;
    logic             res_valid;

    assign beat_in.data = data_byte;
    assign beat_in.eom  = end_of_message;
    assign advance      = held_valid && out_ready;

    pwp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .beat_in    (beat_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    pwp_decoder u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .beat      (held_beat),
        .res_valid (res_valid),
        .res       (res)
    );

    pwp_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .res        (res),
        .ready      (out_ready),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item)
    );

    assign item_kind     = item.kind;
    assign field_number  = item.field;
    assign wire_type     = item.wtype;
    assign value         = item.value;
    assign payload_byte  = item.pbyte;
    assign last_of_field = item.last;
    assign error_cause   = item.cause;

endmodule

// ===== dv/protobuf_wire_parser_core_test.sv =====
// Self-checking testbench for the protobuf wire format parser core.
module protobuf_wire_parser_core_test;

    import pwp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       typed;
        logic       has;
        result_t    res;
    } beat_rec_t;

    localparam result_t NO_RES = '0;
    localparam int RANDOM_BEATS_PER_STAGE = 530;
    localparam int HOLD_CYCLES = 400;

    // typed rows carry their expected item, the rest take theirs from the predictor
    localparam beat_rec_t DIRECTED [27] = '{
        '{8'h08, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h96, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b1, 1'b1,
          '{KIND_SCALAR, 32'd1, WT_VARINT, 64'd150, 8'h00, 1'b0, CAUSE_NONE}},
        '{8'h12, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hab, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hcd, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h1a, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h2d, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b1, 1'b1,
          '{KIND_SCALAR, 32'd5, WT_FIX32, 64'hffff_ffff, 8'h00, 1'b0, CAUSE_NONE}},
        '{8'h09, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, 1'b1,
          '{KIND_ERROR, 32'd1, WT_FIX64, 64'd0, 8'h00, 1'b0, CAUSE_TRUNC}},
        '{8'h0f, 1'b1, 1'b1, 1'b1,
          '{KIND_ERROR, 32'd1, 3'd7, 64'd0, 8'h00, 1'b0, CAUSE_WIRE}},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hff, 1'b1, 1'b1, 1'b1,
          '{KIND_ERROR, 32'd0, WT_VARINT, 64'd0, 8'h00, 1'b0, CAUSE_LONG}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_message = 1'b0;
    logic        item_valid;
    logic        item_stall = 1'b0;
    logic [1:0]  item_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last_of_field;
    logic [1:0]  error_cause;

    beat_rec_t   byte_fifo[$];
    result_t     pending_items[$];
    logic [7:0]  msg_bytes[$];
    beat_rec_t   on_port;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stage = -1;
    bit          hold = 1'b0;

    // predictor state
    logic [2:0]  ph = PH_TAG;
    logic [63:0] acc = '0;
    logic [3:0]  bidx = '0;
    logic [63:0] remain = '0;
    logic [31:0] cfield = '0;
    logic [2:0]  cwire = '0;

    protobuf_wire_parser_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item_kind      (item_kind),
        .field_number   (field_number),
        .wire_type      (wire_type),
        .value          (value),
        .payload_byte   (payload_byte),
        .last_of_field  (last_of_field),
        .error_cause    (error_cause)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit raise_error(input logic eom, input logic [1:0] cause,
                                       input logic [31:0] fnum, input logic [2:0] wt,
                                       output result_t r);
        ph = eom ? PH_TAG : PH_DRAIN;
        acc = '0;
        bidx = '0;
        r = '0;
        r.kind = KIND_ERROR;
        r.field = fnum;
        r.wtype = wt;
        r.cause = cause;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic eom,
                                       output result_t r);
        logic [3:0]  idx;
        logic [63:0] v;
        logic [31:0] ef;
        logic [2:0]  ew;
        logic [2:0]  top;
        bit          in_tag;
        bit          last;
        r = '0;
        idx = bidx;
        case (ph)
            PH_TAG, PH_VARINT, PH_LENGTH:
            begin
                in_tag = (ph == PH_TAG);
                ef = in_tag ? 32'd0 : cfield;
                ew = in_tag ? 3'd0 : cwire;
                if (idx > VARINT_LAST_IDX)
                    idx = VARINT_LAST_IDX;
                acc |= 64'(b[6:0]) << (7 * idx);
                if (b[7])
                begin
                    if (idx >= VARINT_LAST_IDX)
                        return raise_error(eom, CAUSE_LONG, ef, ew, r);
                    if (eom)
                        return raise_error(eom, CAUSE_TRUNC, ef, ew, r);
                    bidx = idx + 4'd1;
                    return 1'b0;
                end
                v = acc;
                acc = '0;
                bidx = '0;
                if (in_tag)
                begin
                    cfield = v[34:3];
                    cwire = v[2:0];
                    case (cwire)
                        WT_VARINT: ph = PH_VARINT;
                        WT_FIX64:  ph = PH_FIX64;
                        WT_LEN:    ph = PH_LENGTH;
                        WT_FIX32:  ph = PH_FIX32;
                        default:   return raise_error(eom, CAUSE_WIRE, cfield, cwire, r);
                    endcase
                    if (eom)
                        return raise_error(eom, CAUSE_TRUNC, cfield, cwire, r);
                    return 1'b0;
                end
                r.field = cfield;
                r.wtype = cwire;
                r.value = v;
                if (ph == PH_VARINT)
                begin
                    ph = PH_TAG;
                    r.kind = KIND_SCALAR;
                    return 1'b1;
                end
                if (v != 0 && eom)
                    return raise_error(eom, CAUSE_TRUNC, cfield, cwire, r);
                remain = v;
                ph = (v == 0) ? PH_TAG : PH_PAYLOAD;
                r.kind = KIND_HEADER;
                r.last = (v == 0);
                return 1'b1;
            end
            PH_FIX32, PH_FIX64:
            begin
                top = (ph == PH_FIX32) ? FIX32_LAST_IDX : FIX64_LAST_IDX;
                if (idx > 4'(FIX64_LAST_IDX))
                    idx = 4'(FIX64_LAST_IDX);
                acc |= 64'(b) << (8 * idx);
                if (idx < 4'(top))
                begin
                    if (eom)
                        return raise_error(eom, CAUSE_TRUNC, cfield, cwire, r);
                    bidx = idx + 4'd1;
                    return 1'b0;
                end
                r.kind = KIND_SCALAR;
                r.field = cfield;
                r.wtype = cwire;
                r.value = acc;
                acc = '0;
                bidx = '0;
                ph = PH_TAG;
                return 1'b1;
            end
            PH_PAYLOAD:
            begin
                last = (remain <= 1);
                if (!last && eom)
                    return raise_error(eom, CAUSE_TRUNC, cfield, cwire, r);
                remain = last ? 64'd0 : remain - 64'd1;
                if (last)
                    ph = PH_TAG;
                r.kind = KIND_PAYLOAD;
                r.field = cfield;
                r.wtype = cwire;
                r.pbyte = b;
                r.last = last;
                return 1'b1;
            end
            default:
            begin
                if (eom)
                begin
                    ph = PH_TAG;
                    acc = '0;
                    bidx = '0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return ($urandom_range(9) == 0) ? 64'd0 : v >> $urandom_range(63);
    endfunction

    task automatic put_varint(input logic [63:0] v, input int pad, input bit junk);
        int         n;
        logic [7:0] b;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        if (pad > n)
            n = pad;
        for (int i = 0; i < n; i++)
        begin
            b = 8'((v >> (7 * i)) & 64'h7f);
            if (i == 9 && junk)
                b[6:1] = 6'($urandom);
            b[7] = (i < n - 1);
            msg_bytes.push_back(b);
        end
    endtask

    task automatic put_field(output bit stop);
        logic [31:0] fnum;
        logic [2:0]  wt;
        logic [63:0] tag;
        int          pick;
        int          len;
        stop = 1'b0;
        fnum = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20);
        pick = $urandom_range(99);
        if (pick < 25)
            wt = WT_VARINT;
        else if (pick < 40)
            wt = WT_FIX64;
        else if (pick < 55)
            wt = WT_FIX32;
        else if (pick < 92)
            wt = WT_LEN;
        else
        begin
            do
                wt = 3'($urandom);
            while (wt inside {WT_VARINT, WT_FIX64, WT_LEN, WT_FIX32});
            stop = 1'b1;
        end
        tag = {29'd0, fnum, wt};
        if ($urandom_range(19) == 0)
            tag[63:35] = 29'($urandom);
        put_varint(tag, ($urandom_range(9) == 0) ? $urandom_range(10) : 0,
                   $urandom_range(1));
        if (stop)
            return;
        case (wt)
            WT_VARINT:
                put_varint(rand_value(), ($urandom_range(9) == 0) ? $urandom_range(10) : 0,
                           $urandom_range(1));
            WT_FIX64:
                repeat (8) msg_bytes.push_back(8'($urandom));
            WT_FIX32:
                repeat (4) msg_bytes.push_back(8'($urandom));
            default:
            begin
                if ($urandom_range(29) == 0)
                begin
                    // huge length, message ends inside the payload
                    put_varint({$urandom, $urandom} | 64'h100, 0, 1'b0);
                    repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
                    stop = 1'b1;
                end
                else
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
                    put_varint(64'(len), ($urandom_range(9) == 0) ? $urandom_range(10) : 0,
                               1'b0);
                    repeat (len) msg_bytes.push_back(8'($urandom));
                end
            end
        endcase
    endtask

    task automatic queue_message(inout int sent);
        int        choice;
        bit        stop;
        beat_rec_t rec;
        choice = $urandom_range(99);
        msg_bytes.delete();
        if (choice < 8)
        begin
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
        end
        else
        begin
            stop = 1'b0;
            repeat ($urandom_range(1, 4))
                if (!stop)
                    put_field(stop);
            if (choice < 13)
            begin
                // overlong varint, then junk that must be dropped
                repeat ($urandom_range(10, 12)) msg_bytes.push_back(8'($urandom) | 8'h80);
                repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
            end
            else if (choice < 25)
            begin
                while (msg_bytes.size() > $urandom_range(1, msg_bytes.size()))
                    void'(msg_bytes.pop_back());
            end
        end
        foreach (msg_bytes[i])
        begin
            rec = '0;
            rec.data = msg_bytes[i];
            rec.eom = (i == msg_bytes.size() - 1);
            byte_fifo.push_back(rec);
        end
        sent += msg_bytes.size();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        result_t r;
        bit      has;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= 8'h00;
            end_of_message <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                has = decode_byte(on_port.data, on_port.eom, r);
                if (on_port.typed)
                begin
                    has = on_port.has;
                    r = on_port.res;
                end
                if (has)
                    pending_items.push_back(r);
            end
            if (!byte_valid || !byte_stall)
            begin
                if (byte_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_port = byte_fifo.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= on_port.data;
                    end_of_message <= on_port.eom;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : take_items
        result_t got;
        result_t want;
        if (!rst_n)
            item_stall <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                got = {item_kind, field_number, wire_type, value, payload_byte,
                       last_of_field, error_cause};
                if (pending_items.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: kind=%0d field=%0d wire=%0d value=%h",
                                 got.kind, got.field, got.wtype, got.value);
                end
                else
                begin
                    want = pending_items.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind=%0d field=%0d wire=%0d ",
                                      "value=%h byte=%h last=%b cause=%0d, got kind=%0d ",
                                      "field=%0d wire=%0d value=%h byte=%h last=%b cause=%0d"},
                                     want.kind, want.field, want.wtype, want.value,
                                     want.pbyte, want.last, want.cause,
                                     got.kind, got.field, got.wtype, got.value,
                                     got.pbyte, got.last, got.cause);
                    end
                end
            end
            item_stall <= hold || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off so the core backs up and stalls its input
    initial
    begin
        wait (stage == 2);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int s = 0; s < 3; s++)
        begin
            send_idle_pct = (s == 0) ? 15 : (s == 1) ? 75 : 0;
            recv_idle_pct = (s == 0) ? 75 : (s == 1) ? 15 : 0;
            stage = s;
            if (s == 0)
                foreach (DIRECTED[i])
                    byte_fifo.push_back(DIRECTED[i]);
            sent = 0;
            while (sent < RANDOM_BEATS_PER_STAGE)
                queue_message(sent);
            @(posedge clk);
            while (byte_fifo.size() != 0 || byte_valid || pending_items.size() != 0)
                @(posedge clk);
        end
        repeat (20) @(posedge clk);
        mismatches += pending_items.size();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
